[design/touch_sample_filter_map_core_defines.svh]
// assertion macros shared by the touch sample filter and map block
// no dependencies; included by files that carry concurrent assertions
`ifndef TOUCH_SAMPLE_FILTER_MAP_CORE_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_MAP_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSFM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TSFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tsfm_pkg.sv]
// shared types and constants of the touch sample filter and map block
// no dependencies
package tsfm_pkg;

  localparam int unsigned RawW   = 12;
  localparam int unsigned DiffW  = RawW + 1;
  localparam int unsigned ScaleW = 20;
  localparam int unsigned ProdW  = DiffW + ScaleW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned TruncW = ProdW - FracW;
  localparam int unsigned PosW   = 12;
  localparam int unsigned SumW   = TruncW + 1;
  localparam int unsigned ScrW   = 11;
  localparam int unsigned MidW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = ScaleW;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_NOISE_LIMIT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTER_X_RAW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Y_RAW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_SCALE_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INV_SCALE_Y   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 3'd6;

  // register reset values
  localparam logic [RawW-1:0]   RST_NOISE_LIMIT   = 12'd10;
  localparam logic [RawW-1:0]   RST_CENTER_RAW    = 12'd2048;
  localparam logic [ScaleW-1:0] RST_INV_SCALE     = '0;
  localparam logic [ScrW-1:0]   RST_SCREEN_WIDTH  = 11'd240;
  localparam logic [ScrW-1:0]   RST_SCREEN_HEIGHT = 11'd320;

  localparam logic [MidW-1:0] MID_X = 8'd120;
  localparam logic [MidW-1:0] MID_Y = 8'd160;

  localparam logic signed [DiffW-1:0] CLEAR_MARGIN_X = 13'sd24;
  localparam logic signed [PosW-1:0]  CLEAR_MARGIN_Y = 12'sd16;

  localparam logic signed [SumW-1:0] POS_MAX = 18'sd2047;
  localparam logic signed [SumW-1:0] POS_MIN = -18'sd2048;
  localparam logic signed [ProdW-1:0] TRUNC_BIAS = 33'sd65535;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_REJECT = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_DRAW   = 3'd4
  } action_e;

  // per-beat status carried alongside the datapath
  typedef struct packed {
    logic valid;
    logic pen;
    logic pass;
  } stat_t;

endpackage

[design/touch_sample_filter_map_core.sv]
// top level of the touch sample filter and map block: config registers and the pipeline
// depends on tsfm_pkg, tsfm_filter, tsfm_map_axis, tsfm_out_stage and the defines header
//
// channel   direction  handshake             payload
// sample    in         start & !busy         pen_down, first_x/y, second_x/y
// result    out        done (one cycle)      action, pos_x, pos_y
// config    in         cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// one sample beat per cycle; the result beat is shown on done once the sample has left
// the last of the register stages
// four register stages: filter/offset, scale multiply, truncate/saturate, classify
// busy is always low: the pipeline never stalls and the receiver takes every result
// reset clears the valid bits and loads the register defaults; payload flops are not reset
`include "touch_sample_filter_map_core_defines.svh"

module touch_sample_filter_map_core import tsfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   pen_down_i,
  input  logic [RawW-1:0]        first_x_i,
  input  logic [RawW-1:0]        first_y_i,
  input  logic [RawW-1:0]        second_x_i,
  input  logic [RawW-1:0]        second_y_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_wdata_i,
  output logic                   done_o,
  output logic [2:0]             action_o,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o
);

  logic [RawW-1:0]   noise_limit_q, center_x_q, center_y_q;
  logic [ScaleW-1:0] inv_scale_x_q, inv_scale_y_q;
  logic [ScrW-1:0]   screen_width_q, screen_height_q;

  stat_t                   stat1, stat2_q, stat3_q;
  logic signed [DiffW-1:0] diff_x, diff_y;
  logic signed [PosW-1:0]  pos_x, pos_y;
  action_e                 action;
  logic                    accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_limit_q   <= RST_NOISE_LIMIT;
      center_x_q      <= RST_CENTER_RAW;
      center_y_q      <= RST_CENTER_RAW;
      inv_scale_x_q   <= RST_INV_SCALE;
      inv_scale_y_q   <= RST_INV_SCALE;
      screen_width_q  <= RST_SCREEN_WIDTH;
      screen_height_q <= RST_SCREEN_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NOISE_LIMIT:   noise_limit_q   <= cfg_wdata_i[RawW-1:0];
        REG_CENTER_X_RAW:  center_x_q      <= cfg_wdata_i[RawW-1:0];
        REG_CENTER_Y_RAW:  center_y_q      <= cfg_wdata_i[RawW-1:0];
        REG_INV_SCALE_X:   inv_scale_x_q   <= cfg_wdata_i[ScaleW-1:0];
        REG_INV_SCALE_Y:   inv_scale_y_q   <= cfg_wdata_i[ScaleW-1:0];
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[ScrW-1:0];
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[ScrW-1:0];
        default: ;
      endcase
    end
  end

  tsfm_filter u_filter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pen_down_i    (pen_down_i),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .noise_limit_i (noise_limit_q),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .stat_o        (stat1),
    .diff_x_o      (diff_x),
    .diff_y_o      (diff_y)
  );

  // status follows the two map stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat2_q <= '0;
      stat3_q <= '0;
    end else begin
      stat2_q <= stat1;
      stat3_q <= stat2_q;
    end
  end

  tsfm_map_axis u_map_x (
    .clk_i   (clk_i),
    .diff_i  (diff_x),
    .scale_i ($signed(inv_scale_x_q)),
    .mid_i   (MID_X),
    .pos_o   (pos_x)
  );

  tsfm_map_axis u_map_y (
    .clk_i   (clk_i),
    .diff_i  (diff_y),
    .scale_i ($signed(inv_scale_y_q)),
    .mid_i   (MID_Y),
    .pos_o   (pos_y)
  );

  tsfm_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stat_i          (stat3_q),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .done_o          (done_o),
    .action_o        (action),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o)
  );

  assign action_o = action;

  `TSFM_ASSERT_NOW(a_done_from_start, clk_i, rst_ni, done_o, $past(start, 4),
    "result beat without an accepted sample four cycles earlier")
  `TSFM_ASSERT_NOW(a_zero_pos, clk_i, rst_ni,
    done_o && (action == ACT_NONE || action == ACT_REJECT),
    pos_x_o == '0 && pos_y_o == '0, "no-touch or rejected beat carries a position")
  `TSFM_ASSERT_NOW(a_clear_zone, clk_i, rst_ni, done_o && action == ACT_CLEAR,
    !pos_y_o[PosW-1] && !pos_x_o[PosW-1] && pos_y_o < CLEAR_MARGIN_Y,
    "clear zone beat outside the top band")
  `TSFM_ASSERT_NEXT(a_stage_chain, clk_i, rst_ni, stat1.valid, stat2_q.valid,
    "valid bit lost between filter and multiply stage")

endmodule

[design/tsfm_filter.sv]
// stage 1: noise check, averaging and center offset of both axes
// depends on tsfm_pkg
module tsfm_filter import tsfm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    pen_down_i,
  input  logic [RawW-1:0]         first_x_i,
  input  logic [RawW-1:0]         first_y_i,
  input  logic [RawW-1:0]         second_x_i,
  input  logic [RawW-1:0]         second_y_i,
  input  logic [RawW-1:0]         noise_limit_i,
  input  logic [RawW-1:0]         center_x_i,
  input  logic [RawW-1:0]         center_y_i,
  output stat_t                   stat_o,
  output logic signed [DiffW-1:0] diff_x_o,
  output logic signed [DiffW-1:0] diff_y_o
);

  logic [RawW-1:0]         adx, ady;
  logic [RawW:0]           sum_x, sum_y;
  logic [RawW-1:0]         avg_x, avg_y;
  stat_t                   stat_d, stat_q;
  logic signed [DiffW-1:0] diff_x_d, diff_y_d, diff_x_q, diff_y_q;

  always_comb begin
    adx = (first_x_i > second_x_i) ? first_x_i - second_x_i : second_x_i - first_x_i;
    ady = (first_y_i > second_y_i) ? first_y_i - second_y_i : second_y_i - first_y_i;
    sum_x = {1'b0, first_x_i} + {1'b0, second_x_i};
    sum_y = {1'b0, first_y_i} + {1'b0, second_y_i};
    avg_x = sum_x[RawW:1];
    avg_y = sum_y[RawW:1];
    diff_x_d = $signed({1'b0, avg_x}) - $signed({1'b0, center_x_i});
    diff_y_d = $signed({1'b0, avg_y}) - $signed({1'b0, center_y_i});
    stat_d.valid = accept_i;
    stat_d.pen   = pen_down_i;
    stat_d.pass  = (adx < noise_limit_i) && (ady < noise_limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else begin
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_x_q <= diff_x_d;
    diff_y_q <= diff_y_d;
  end

  assign stat_o   = stat_q;
  assign diff_x_o = diff_x_q;
  assign diff_y_o = diff_y_q;

endmodule

[design/tsfm_map_axis.sv]
// stages 2 and 3 of one axis: scale multiply, then truncation, offset and saturation
// depends on tsfm_pkg
module tsfm_map_axis import tsfm_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [DiffW-1:0]  diff_i,
  input  logic signed [ScaleW-1:0] scale_i,
  input  logic [MidW-1:0]          mid_i,
  output logic signed [PosW-1:0]   pos_o
);

  logic signed [ProdW-1:0]  prod_d, prod_q;
  logic signed [ProdW-1:0]  biased;
  logic signed [TruncW-1:0] trunc;
  logic signed [SumW-1:0]   pos_full;
  logic signed [PosW-1:0]   pos_d, pos_q;

  assign prod_d = diff_i * scale_i;

  always_comb begin
    // bias negatives so the arithmetic shift rounds toward zero
    biased   = prod_q + (prod_q[ProdW-1] ? TRUNC_BIAS : '0);
    trunc    = biased[ProdW-1:FracW];
    pos_full = $signed({{(SumW-MidW){1'b0}}, mid_i}) - $signed({trunc[TruncW-1], trunc});
    if (pos_full > POS_MAX) begin
      pos_d = POS_MAX[PosW-1:0];
    end else if (pos_full < POS_MIN) begin
      pos_d = POS_MIN[PosW-1:0];
    end else begin
      pos_d = pos_full[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pos_q  <= pos_d;
  end

  assign pos_o = pos_q;

endmodule

[design/tsfm_out_stage.sv]
// stage 4: point classification and the registered result beat
// depends on tsfm_pkg
module tsfm_out_stage import tsfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stat_t                  stat_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic [ScrW-1:0]        screen_width_i,
  input  logic [ScrW-1:0]        screen_height_i,
  output logic                   done_o,
  output action_e                action_o,
  output logic signed [PosW-1:0] pos_x_o,
  output logic signed [PosW-1:0] pos_y_o
);

  logic                    off;
  logic                    clear;
  logic signed [DiffW-1:0] clear_lim;
  logic                    done_d, done_q;
  action_e                 action_d, action_q;
  logic signed [PosW-1:0]  pos_x_d, pos_y_d, pos_x_q, pos_y_q;

  always_comb begin
    // size compares only matter when both positions are non-negative
    off = pos_x_i[PosW-1] || pos_y_i[PosW-1]
       || (pos_x_i >= $signed({1'b0, screen_width_i}))
       || (pos_y_i >= $signed({1'b0, screen_height_i}));
    clear_lim = $signed({2'b00, screen_width_i}) - CLEAR_MARGIN_X;
    clear = ($signed({pos_x_i[PosW-1], pos_x_i}) > clear_lim) && (pos_y_i < CLEAR_MARGIN_Y);

    done_d  = stat_i.valid;
    pos_x_d = '0;
    pos_y_d = '0;
    if (!stat_i.pen) begin
      action_d = ACT_NONE;
    end else if (!stat_i.pass) begin
      action_d = ACT_REJECT;
    end else begin
      pos_x_d = pos_x_i;
      pos_y_d = pos_y_i;
      if (off) begin
        action_d = ACT_OFF;
      end else if (clear) begin
        action_d = ACT_CLEAR;
      end else begin
        action_d = ACT_DRAW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    pos_x_q  <= pos_x_d;
    pos_y_q  <= pos_y_d;
  end

  assign done_o   = done_q;
  assign action_o = action_q;
  assign pos_x_o  = pos_x_q;
  assign pos_y_o  = pos_y_q;

endmodule

[tb/tb.sv]
// testbench for touch_sample_filter_map_core: directed and random touch samples under
// several register setups, each result beat checked against a behavioral predictor
// depends on tsfm_pkg and touch_sample_filter_map_core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsfm_pkg::*;

  typedef struct {
    logic            pen;
    logic [RawW-1:0] fx;
    logic [RawW-1:0] fy;
    logic [RawW-1:0] sx;
    logic [RawW-1:0] sy;
    bit              after_drain;
  } touch_t;

  typedef struct {
    action_e               act;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
  } point_t;

  typedef struct {
    int noise;
    int cx;
    int cy;
    int kx;
    int ky;
    int w;
    int h;
  } setup_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   start       = 1'b0;
  logic                   busy;
  logic                   pen_down_i  = 1'b0;
  logic [RawW-1:0]        first_x_i   = '0;
  logic [RawW-1:0]        first_y_i   = '0;
  logic [RawW-1:0]        second_x_i  = '0;
  logic [RawW-1:0]        second_y_i  = '0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i   = REG_NOISE_LIMIT;
  logic [CfgDataW-1:0]    cfg_wdata_i = '0;
  logic                   done_o;
  logic [2:0]             action_o;
  logic signed [PosW-1:0] pos_x_o;
  logic signed [PosW-1:0] pos_y_o;

  touch_t sample_q[$];
  point_t point_q[$];
  setup_t regs;
  int     gap_pct = 0;
  int     n_err   = 0;

  touch_sample_filter_map_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pen_down_i  (pen_down_i),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .action_o    (action_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic log_mismatch(string msg);
    n_err++;
    if (n_err <= 50) $display("mismatch: %s", msg);
  endtask

  // scale term truncates toward zero, then saturate to 12 bit signed
  function automatic int pixel_of(int avg, int center, int scale, int mid);
    longint prod;
    longint pos;
    prod = longint'(avg - center) * longint'(scale);
    pos = longint'(mid) - prod / 65536;
    if (pos > longint'(POS_MAX)) pos = longint'(POS_MAX);
    if (pos < longint'(POS_MIN)) pos = longint'(POS_MIN);
    return int'(pos);
  endfunction

  function automatic point_t predict_point(touch_t t);
    point_t p;
    int dx;
    int dy;
    int x;
    int y;
    p.act = ACT_NONE;
    p.px = '0;
    p.py = '0;
    dx = int'(t.fx) - int'(t.sx);
    dy = int'(t.fy) - int'(t.sy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (t.pen) begin
      if (!(dx < regs.noise && dy < regs.noise)) begin
        p.act = ACT_REJECT;
      end else begin
        x = pixel_of((int'(t.fx) + int'(t.sx)) / 2, regs.cx, regs.kx, int'(MID_X));
        y = pixel_of((int'(t.fy) + int'(t.sy)) / 2, regs.cy, regs.ky, int'(MID_Y));
        if (x < 0 || y < 0 || x >= regs.w || y >= regs.h) p.act = ACT_OFF;
        else if (x > regs.w - int'(CLEAR_MARGIN_X) && y < int'(CLEAR_MARGIN_Y)) p.act = ACT_CLEAR;
        else p.act = ACT_DRAW;
        p.px = PosW'(x);
        p.py = PosW'(y);
      end
    end
    return p;
  endfunction

  function automatic touch_t pair_item(bit pen, int fx, int fy, int sx, int sy);
    touch_t t;
    t.pen = pen;
    t.fx = RawW'(fx);
    t.fy = RawW'(fy);
    t.sx = RawW'(sx);
    t.sy = RawW'(sy);
    t.after_drain = 1'b0;
    return t;
  endfunction

  // two readings whose floor average lands near the raw value of the target pixel
  task automatic place_pair(input int target, input int mid, input int center, input int scale,
                            output logic [RawW-1:0] a, output logic [RawW-1:0] b);
    longint r;
    int     lim;
    int     d;
    int     lo;
    int     hi;
    if (scale == 0) r = $urandom_range(4095);
    else r = longint'(center) + (longint'(mid - target) * 65536) / scale;
    if (r < 0) r = 0;
    if (r > 4095) r = 4095;
    lim = (regs.noise > 40) ? 40 : regs.noise - 1;
    if (lim < 0) lim = 0;
    // sometimes sit right on the noise limit
    if ($urandom_range(4) == 0) d = regs.noise - 1 + int'($urandom_range(1));
    else d = $urandom_range(lim);
    if (d < 0) d = 0;
    if (d > 4095) d = 4095;
    lo = int'(r) - d / 2;
    hi = lo + d;
    if (lo < 0) begin
      hi = hi - lo;
      lo = 0;
    end
    if (hi > 4095) begin
      lo = lo - (hi - 4095);
      hi = 4095;
    end
    if ($urandom_range(1)) begin
      a = RawW'(lo);
      b = RawW'(hi);
    end else begin
      a = RawW'(hi);
      b = RawW'(lo);
    end
  endtask

  task automatic random_touch(output touch_t t);
    int pick;
    int tx;
    int ty;
    pick = $urandom_range(99);
    t.after_drain = 1'b0;
    if (pick < 25) begin
      // pen up or plain noise with fully random readings
      t.pen = (pick >= 10);
      t.fx = RawW'($urandom);
      t.fy = RawW'($urandom);
      t.sx = RawW'($urandom);
      t.sy = RawW'($urandom);
    end else begin
      t.pen = 1'b1;
      if ($urandom_range(4) == 0) begin
        tx = regs.w - 1 - int'($urandom_range(23));
        ty = $urandom_range(15);
      end else begin
        tx = int'($urandom_range(regs.w + 40)) - 20;
        ty = int'($urandom_range(regs.h + 40)) - 20;
      end
      place_pair(tx, int'(MID_X), regs.cx, regs.kx, t.fx, t.sx);
      place_pair(ty, int'(MID_Y), regs.cy, regs.ky, t.fy, t.sy);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_NOISE_LIMIT:   regs.noise = int'(val[RawW-1:0]);
      REG_CENTER_X_RAW:  regs.cx = int'(val[RawW-1:0]);
      REG_CENTER_Y_RAW:  regs.cy = int'(val[RawW-1:0]);
      REG_INV_SCALE_X:   regs.kx = int'($signed(val));
      REG_INV_SCALE_Y:   regs.ky = int'($signed(val));
      REG_SCREEN_WIDTH:  regs.w = int'(val[ScrW-1:0]);
      REG_SCREEN_HEIGHT: regs.h = int'(val[ScrW-1:0]);
      default: ;
    endcase
  endtask

  // unused upper data bits carry junk
  task automatic apply_setup(setup_t s);
    write_reg(REG_NOISE_LIMIT, {8'($urandom), 12'(s.noise)});
    write_reg(REG_CENTER_X_RAW, {8'($urandom), 12'(s.cx)});
    write_reg(REG_CENTER_Y_RAW, {8'($urandom), 12'(s.cy)});
    write_reg(REG_INV_SCALE_X, 20'(s.kx));
    write_reg(REG_INV_SCALE_Y, 20'(s.ky));
    write_reg(REG_SCREEN_WIDTH, {9'($urandom), 11'(s.w)});
    write_reg(REG_SCREEN_HEIGHT, {9'($urandom), 11'(s.h)});
  endtask

  // checked on the falling edge so every update of the rising edge has landed
  task automatic settle();
    @(negedge clk_i);
    while (sample_q.size() != 0 || start || point_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive
    touch_t cur;
    touch_t nxt;
    if (start && !busy) begin
      cur = pair_item(pen_down_i, first_x_i, first_y_i, second_x_i, second_y_i);
      point_q.push_back(predict_point(cur));
    end
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // beat not taken yet, hold it
    end else if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct &&
                 !(sample_q[0].after_drain && point_q.size() != 0)) begin
      nxt = sample_q.pop_front();
      start <= 1'b1;
      pen_down_i <= nxt.pen;
      first_x_i <= nxt.fx;
      first_y_i <= nxt.fy;
      second_x_i <= nxt.sx;
      second_y_i <= nxt.sy;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch
    point_t want;
    if (rst_ni && done_o) begin
      if (point_q.size() == 0) begin
        log_mismatch("result beat with nothing pending");
      end else begin
        want = point_q.pop_front();
        if (action_o !== want.act || pos_x_o !== want.px || pos_y_o !== want.py)
          log_mismatch($sformatf("action %0d pos %0d,%0d, expected action %0d pos %0d,%0d",
                                 action_o, pos_x_o, pos_y_o, want.act, want.px, want.py));
      end
    end
  end

  initial begin : stim
    touch_t t;
    setup_t s;
    regs = '{int'(RST_NOISE_LIMIT), int'(RST_CENTER_RAW), int'(RST_CENTER_RAW),
             int'($signed(RST_INV_SCALE)), int'($signed(RST_INV_SCALE)),
             int'(RST_SCREEN_WIDTH), int'(RST_SCREEN_HEIGHT)};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setup: zero scale puts every accepted point at the midpoint
    sample_q.push_back(pair_item(0, 0, 0, 0, 0));
    sample_q.push_back(pair_item(0, 4095, 4095, 4095, 4095));
    sample_q.push_back(pair_item(1, 0, 0, 0, 0));
    sample_q.push_back(pair_item(1, 4095, 4095, 4095, 4095));
    sample_q.push_back(pair_item(1, 0, 100, 9, 100));
    sample_q.push_back(pair_item(1, 0, 100, 10, 100));
    sample_q.push_back(pair_item(1, 500, 4095, 500, 4085));
    sample_q.push_back(pair_item(1, 4095, 7, 4086, 0));
    sample_q.push_back(pair_item(1, 4095, 0, 0, 0));
    settle();

    // unit scale, small screen: clear zone edges, negatives and screen edges
    apply_setup('{10, 0, 0, 65536, 65536, 120, 60});
    sample_q.push_back(pair_item(1, 1, 145, 1, 145));
    sample_q.push_back(pair_item(1, 23, 145, 23, 145));
    sample_q.push_back(pair_item(1, 24, 145, 24, 145));
    sample_q.push_back(pair_item(1, 1, 144, 1, 144));
    sample_q.push_back(pair_item(1, 0, 145, 0, 145));
    sample_q.push_back(pair_item(1, 121, 130, 121, 130));
    sample_q.push_back(pair_item(1, 60, 161, 60, 161));
    sample_q.push_back(pair_item(1, 60, 100, 60, 100));
    sample_q.push_back(pair_item(1, 60, 101, 60, 101));
    settle();

    // extreme scales and centers: saturation both ways, widest noise window
    apply_setup('{4095, 0, 4095, 524287, -524288, 2047, 2047});
    sample_q.push_back(pair_item(1, 0, 0, 0, 0));
    sample_q.push_back(pair_item(1, 4095, 4095, 4095, 4095));
    sample_q.push_back(pair_item(1, 0, 4095, 4094, 1));
    sample_q.push_back(pair_item(1, 0, 0, 4095, 0));
    settle();

    // zero noise limit rejects every touch
    apply_setup('{0, 2048, 2048, 0, 0, 1, 1});
    sample_q.push_back(pair_item(1, 77, 77, 77, 77));
    sample_q.push_back(pair_item(0, 77, 77, 77, 77));
    sample_q.push_back(pair_item(1, 4095, 0, 4095, 0));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      gap_pct = (ph < 2) ? 17 : (ph < 4) ? 78 : 0;
      s.noise = ($urandom_range(7) == 0) ? 4095 : $urandom_range(1, 64);
      s.cx = $urandom_range(600, 3500);
      s.cy = $urandom_range(600, 3500);
      s.kx = $urandom_range(2000, 14000);
      s.ky = $urandom_range(2000, 14000);
      if ($urandom_range(1)) s.kx = -s.kx;
      if ($urandom_range(1)) s.ky = -s.ky;
      if ($urandom_range(9) == 0) s.kx = int'($signed(20'($urandom)));
      if ($urandom_range(9) == 0) s.ky = int'($signed(20'($urandom)));
      s.w = ($urandom_range(3) == 0) ? $urandom_range(1, 2047) : $urandom_range(100, 480);
      s.h = ($urandom_range(3) == 0) ? $urandom_range(1, 2047) : $urandom_range(100, 480);
      apply_setup(s);
      for (int i = 0; i < 262; i++) begin
        random_touch(t);
        // now and then let the pipeline run dry first
        if (i % 97 == 50) t.after_drain = 1'b1;
        sample_q.push_back(t);
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (point_q.size() != 0) log_mismatch("results still pending at end of run");
    if (n_err == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
